// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL; the top-level evaluator includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/ase_pkg.sv =====
package ase_pkg;

  localparam int unsigned ArgW      = 31;
  localparam int unsigned SumW      = 36;
  localparam int unsigned SumMagW   = 34;
  localparam int unsigned CountW    = 9;
  localparam int unsigned LimitW    = 8;
  localparam int unsigned DenW      = 10;
  localparam int unsigned FracBits  = 30;
  localparam int unsigned DivSteps  = 31;
  localparam int unsigned DivCntW   = 5;
  localparam int unsigned PcW       = 4;
  localparam int unsigned ProgLen   = 9;

  localparam logic [PcW-1:0] PcIdle = 4'd0;
  localparam logic [PcW-1:0] PcLoop = 4'd3;
  localparam logic [PcW-1:0] PcDiv  = 4'd5;
  localparam logic [PcW-1:0] PcEmit = 4'd8;

  localparam logic [ArgW-1:0] ThrReset = 31'd11;

  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LOAD     = 4'd1,
    OP_MUL_SQ   = 4'd2,
    OP_SET_SQ   = 4'd3,
    OP_DIV_INIT = 4'd4,
    OP_DIV_STEP = 4'd5,
    OP_ADD      = 4'd6,
    OP_SET_MAG  = 4'd7,
    OP_EMIT     = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT      = 3'd0,
    C_ALWAYS    = 3'd1,
    C_NOT_START = 3'd2,
    C_I_GT_LIM  = 3'd3,
    C_DIV_MORE  = 3'd4,
    C_TERM_LOW  = 3'd5
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic           squash;
    logic [PcW-1:0] target;
  } uword_t;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic i_gt_limit;
    logic div_more;
    logic term_low;
  } status_t;

  // The squash bit drops the step's operation when its jump is taken.
  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{op: OP_LOAD,     cond: C_NOT_START, squash: 1'b1, target: PcIdle};
      4'd1:    w = '{op: OP_MUL_SQ,   cond: C_NEXT,      squash: 1'b0, target: PcIdle};
      4'd2:    w = '{op: OP_SET_SQ,   cond: C_NEXT,      squash: 1'b0, target: PcIdle};
      4'd3:    w = '{op: OP_NONE,     cond: C_I_GT_LIM,  squash: 1'b0, target: PcEmit};
      4'd4:    w = '{op: OP_DIV_INIT, cond: C_NEXT,      squash: 1'b0, target: PcIdle};
      4'd5:    w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,  squash: 1'b0, target: PcDiv};
      4'd6:    w = '{op: OP_ADD,      cond: C_TERM_LOW,  squash: 1'b1, target: PcEmit};
      4'd7:    w = '{op: OP_SET_MAG,  cond: C_ALWAYS,    squash: 1'b0, target: PcLoop};
      4'd8:    w = '{op: OP_EMIT,     cond: C_ALWAYS,    squash: 1'b0, target: PcIdle};
      default: w = '{op: OP_NONE,     cond: C_ALWAYS,    squash: 1'b0, target: PcIdle};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ase_divider.sv =====
module ase_divider
  import ase_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 init_i,
  input  logic                 step_i,
  input  logic [ArgW-1:0]      dividend_i,
  input  logic [DenW-1:0]      divisor_i,
  output logic [ArgW-1:0]      quotient_o,
  output logic                 more_o
);

  logic [DenW-1:0]    rem_q, rem_d;
  logic [ArgW-1:0]    quo_q, quo_d;
  logic [DenW-1:0]    div_q, div_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]      trial;
  logic               fits;

  assign trial = {rem_q, quo_q[ArgW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    div_d = div_q;
    cnt_d = cnt_q;
    if (init_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      div_d = divisor_i;
      cnt_d = '0;
    end else if (step_i) begin
      rem_d = fits ? DenW'(trial - {1'b0, div_q}) : trial[DenW-1:0];
      quo_d = {quo_q[ArgW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
    cnt_q <= cnt_d;
  end

  assign quotient_o = quo_q;
  assign more_o     = cnt_q != DivCntW'(DivSteps - 1);

endmodule

// ===== rtl/ase_datapath.sv =====
module ase_datapath
  import ase_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 255
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_t                    ctrl_i,
  input  logic [LimitW-1:0]        term_limit_i,
  input  logic signed [ArgW-1:0]   argument_i,
  input  logic [ArgW-1:0]          threshold_i,
  output status_t                  status_o,
  output logic signed [SumW-1:0]   series_sum_o,
  output logic [CountW-1:0]        terms_added_o,
  output logic                     done_o
);

  localparam logic [SumMagW:0] SumMax = {1'b0, {SumMagW{1'b1}}};

  logic [ArgW-1:0]     mag_q, mag_d;
  logic [ArgW-1:0]     sq_q, sq_d;
  logic [2*ArgW-1:0]   prod_q, prod_d;
  logic [SumMagW-1:0]  sum_q, sum_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [CountW-1:0]   idx_q, idx_d;
  logic [LimitW-1:0]   limit_q, limit_d;
  logic                neg_q, neg_d;
  logic [SumW-1:0]     res_q, res_d;
  logic [CountW-1:0]   terms_q, terms_d;
  logic                done_q;

  logic [ArgW-1:0]     arg_u;
  logic [ArgW-1:0]     mul_b;
  logic [SumMagW:0]    sum_wide;
  logic [SumW-1:0]     sum_ext;
  logic [ArgW-1:0]     term;
  logic [DenW-1:0]     den;

  assign arg_u    = ArgW'(argument_i);
  assign den      = {idx_q, 1'b1};
  assign mul_b    = (ctrl_i.op == OP_MUL_SQ) ? mag_q : sq_q;
  assign sum_wide = {1'b0, sum_q} + (SumMagW+1)'(term);
  assign sum_ext  = SumW'(sum_q);

  ase_divider u_div (
    .clk_i      (clk_i),
    .init_i     (ctrl_i.op == OP_DIV_INIT),
    .step_i     (ctrl_i.op == OP_DIV_STEP),
    .dividend_i (mag_q),
    .divisor_i  (den),
    .quotient_o (term),
    .more_o     (status_o.div_more)
  );

  assign status_o.i_gt_limit = idx_q > {1'b0, limit_q};
  assign status_o.term_low   = term < threshold_i;

  always_comb begin
    mag_d   = mag_q;
    sq_d    = sq_q;
    prod_d  = prod_q;
    sum_d   = sum_q;
    count_d = count_q;
    idx_d   = idx_q;
    limit_d = limit_q;
    neg_d   = neg_q;
    res_d   = res_q;
    terms_d = terms_q;
    case (ctrl_i.op)
      OP_LOAD: begin
        neg_d   = arg_u[ArgW-1];
        mag_d   = arg_u[ArgW-1] ? ArgW'(~arg_u + 1'b1) : arg_u;
        sum_d   = '0;
        count_d = '0;
        idx_d   = '0;
        limit_d = (32'(term_limit_i) > 32'(MAX_TERMS)) ? LimitW'(MAX_TERMS) : term_limit_i;
      end
      OP_MUL_SQ: begin
        prod_d = mag_q * mul_b;
      end
      OP_SET_SQ: begin
        sq_d = prod_q[FracBits+ArgW-1:FracBits];
      end
      OP_ADD: begin
        sum_d   = (sum_wide > SumMax) ? SumMagW'(SumMax) : sum_wide[SumMagW-1:0];
        count_d = count_q + 1'b1;
        prod_d  = mag_q * mul_b;
      end
      OP_SET_MAG: begin
        mag_d = prod_q[FracBits+ArgW-1:FracBits];
        idx_d = idx_q + 1'b1;
      end
      OP_EMIT: begin
        res_d   = neg_q ? SumW'(~sum_ext + 1'b1) : sum_ext;
        terms_d = count_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    sq_q    <= sq_d;
    prod_q  <= prod_d;
    sum_q   <= sum_d;
    count_q <= count_d;
    idx_q   <= idx_d;
    limit_q <= limit_d;
    neg_q   <= neg_d;
    res_q   <= res_d;
    terms_q <= terms_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.op == OP_EMIT;
    end
  end

  assign series_sum_o  = signed'(res_q);
  assign terms_added_o = terms_q;
  assign done_o        = done_q;

endmodule

// ===== rtl/ase_sequencer.sv =====
module ase_sequencer
  import ase_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  status_t status_i,
  output ctrl_t   ctrl_o,
  output logic    busy
);

  logic [PcW-1:0] pc_q, pc_d;
  uword_t         word;
  logic           jump;

  assign word = ucode(pc_q);

  always_comb begin
    case (word.cond)
      C_NEXT:      jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NOT_START: jump = !start;
      C_I_GT_LIM:  jump = status_i.i_gt_limit;
      C_DIV_MORE:  jump = status_i.div_more;
      C_TERM_LOW:  jump = status_i.term_low;
      default:     jump = 1'b1;
    endcase
  end

  assign pc_d      = jump ? word.target : pc_q + 1'b1;
  assign ctrl_o.op = (jump && word.squash) ? OP_NONE : word.op;
  assign busy      = pc_q != PcIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/atanh_series_evaluator.sv =====
// The sum ends when the term index passes the term limit or when a term falls
// below the stop threshold. The serial divider yields one quotient bit per cycle.
// One item at a time: busy stays high until the result strobe; done_o is high
// for one cycle and the receiver cannot stall. Reset clears the sequencer and
// loads the stop threshold with 11.
`include "assert_macros.svh"

module atanh_series_evaluator
  import ase_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 255
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [LimitW-1:0]        term_limit_i,
  input  logic signed [ArgW-1:0]   argument_i,
  output logic                     done_o,
  output logic signed [SumW-1:0]   series_sum_o,
  output logic [CountW-1:0]        terms_added_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [ArgW-1:0]          cfg_data_i
);

  ctrl_t           ctrl;
  status_t         status;
  logic [ArgW-1:0] thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  ase_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy     (busy)
  );

  ase_datapath #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .term_limit_i  (term_limit_i),
    .argument_i    (argument_i),
    .threshold_i   (thr_q),
    .status_o      (status),
    .series_sum_o  (series_sum_o),
    .terms_added_o (terms_added_o),
    .done_o        (done_o)
  );

  `ASSERT_CLK(a_done_idle, clk_i, rst_ni, done_o |-> !busy)
  `ASSERT_CLK(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `ASSERT_CLK(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o)
  `ASSERT_NEVER(a_count_cap, clk_i, rst_ni, done_o && (terms_added_o > 9'd256))

endmodule

// ===== dv/tb.sv =====
module tb;
  import ase_pkg::*;

  localparam int unsigned MaxTerms = 255;
  localparam logic [63:0] SumMagMax = (64'd1 << SumMagW) - 64'd1;

  typedef struct {
    logic signed [SumW-1:0] sum;
    logic [CountW-1:0]      count;
  } atanh_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic [LimitW-1:0] term_limit_i;
  logic signed [ArgW-1:0] argument_i;
  logic done_o;
  logic signed [SumW-1:0] series_sum_o;
  logic [CountW-1:0] terms_added_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [ArgW-1:0] cfg_data_i;

  logic [ArgW-1:0] stop_thr;
  atanh_result_t expected_sums[$];
  int unsigned max_gap;
  int unsigned err_count;
  int unsigned items_sent;
  int unsigned sums_checked;
  int unsigned thr_writes;

  atanh_series_evaluator #(
    .MAX_TERMS(MaxTerms)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .term_limit_i (term_limit_i),
    .argument_i   (argument_i),
    .done_o       (done_o),
    .series_sum_o (series_sum_o),
    .terms_added_o(terms_added_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic atanh_result_t predict_atanh(input logic [LimitW-1:0] lim,
                                                  input logic [ArgW-1:0] arg);
    atanh_result_t r;
    logic neg;
    logic [ArgW-1:0] arg_abs;
    logic [63:0] mag;
    logic [63:0] sq;
    logic [63:0] sum;
    logic [63:0] trm;
    int unsigned last;
    int unsigned n;
    int unsigned i;
    logic stopped;
    neg = arg[ArgW-1];
    arg_abs = neg ? -arg : arg;
    mag = {{(64-ArgW){1'b0}}, arg_abs};
    last = (lim > MaxTerms) ? MaxTerms : lim;
    sq = (mag * mag) >> FracBits;
    sum = 64'd0;
    n = 0;
    stopped = 1'b0;
    for (i = 0; i <= last && !stopped; i++) begin
      trm = mag / (2 * i + 1);
      if (trm < {{(64-ArgW){1'b0}}, stop_thr}) begin
        stopped = 1'b1;
      end else begin
        sum = sum + trm;
        if (sum > SumMagMax) begin
          sum = SumMagMax;
        end
        n++;
        mag = (mag * sq) >> FracBits;
      end
    end
    r.sum = SumW'(neg ? -sum : sum);
    r.count = CountW'(n);
    return r;
  endfunction

  always @(posedge clk_i) begin
    atanh_result_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected result sum=%0d terms=%0d", $time, series_sum_o,
                 terms_added_o);
        err_count++;
      end else begin
        exp_r = expected_sums.pop_front();
        sums_checked++;
        if (series_sum_o !== exp_r.sum) begin
          $display("%0t: series_sum expected %0d actual %0d", $time, exp_r.sum,
                   series_sum_o);
          err_count++;
        end
        if (terms_added_o !== exp_r.count) begin
          $display("%0t: terms_added expected %0d actual %0d", $time, exp_r.count,
                   terms_added_o);
          err_count++;
        end
      end
    end
  end

  task automatic send_item(input logic [LimitW-1:0] lim, input logic [ArgW-1:0] arg);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    term_limit_i <= lim;
    argument_i <= arg;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_sums.push_back(predict_atanh(lim, arg));
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [ArgW-1:0] value);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    repeat (gap) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    stop_thr = value;
    thr_writes++;
  endtask

  // Runs at the reset threshold, so it also checks the register's reset value.
  task automatic check_corner_arguments();
    send_item(8'd0, 31'h0000_0000);
    send_item(8'd255, 31'h3FFF_FFFF);
    send_item(8'd255, 31'h4000_0001);
    send_item(8'd0, 31'h4000_0000);
    send_item(8'd255, 31'h4000_0000);
    send_item(8'd10, 31'h2000_0000);
    send_item(8'd10, 31'h6000_0000);
    send_item(8'd5, 31'h0000_0001);
    send_item(8'd5, 31'h7FFF_FFFF);
    send_item(8'd200, 31'h0010_0000);
    send_item(8'd128, 31'h2AAA_AAAA);
    send_item(8'd254, 31'h5555_5555);
    send_item(8'd1, 31'h3000_0000);
    wait_idle();
  endtask

  task automatic check_threshold_extremes();
    set_threshold(31'd0);
    send_item(8'd255, 31'h3FFF_FFFF);
    send_item(8'd255, 31'h4000_0000);
    send_item(8'd40, 31'h0000_0400);
    send_item(8'd0, 31'h0000_0000);
    wait_idle();
    set_threshold(31'h4000_0000);
    send_item(8'd255, 31'h4000_0000);
    send_item(8'd255, 31'h3FFF_FFFF);
    send_item(8'd3, 31'h0000_0000);
    wait_idle();
    set_threshold(31'h7FFF_FFFF);
    send_item(8'd255, 31'h4000_0000);
    send_item(8'd7, 31'h1234_5678);
    wait_idle();
  endtask

  task automatic check_random_arguments();
    int unsigned phase;
    int unsigned k;
    int unsigned kind;
    logic [LimitW-1:0] lim;
    logic [ArgW-1:0] arg;
    for (phase = 0; phase < 6; phase++) begin
      max_gap = (phase % 2 == 1) ? 0 : 16;
      case ($urandom_range(0, 3))
        0: set_threshold(ArgW'($urandom_range(0, 16)));
        1: set_threshold(ArgW'($urandom_range(0, 1 << 20)));
        2: set_threshold(ArgW'($urandom_range(0, 1 << 30)));
        default: set_threshold(ThrReset);
      endcase
      for (k = 0; k < 48; k++) begin
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          lim = LimitW'($urandom_range(0, 12));
        end else if (kind < 95) begin
          lim = LimitW'($urandom_range(0, 255));
        end else begin
          lim = 8'hFF;
        end
        case ($urandom_range(0, 3))
          0: arg = ArgW'($urandom);
          1: arg = ArgW'($urandom_range(0, 1 << 20));
          2: arg = ArgW'(32'h3FFF_FFFF - $urandom_range(0, 1 << 16));
          default: arg = ArgW'($urandom_range(0, (1 << 30) - 1));
        endcase
        if ($urandom_range(0, 1) == 1) begin
          arg = -arg;
        end
        send_item(lim, arg);
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    term_limit_i <= '0;
    argument_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    stop_thr = ThrReset;
    max_gap = 16;
    err_count = 0;
    items_sent = 0;
    sums_checked = 0;
    thr_writes = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_corner_arguments();
    check_threshold_extremes();
    check_random_arguments();
    wait_idle();
    repeat (40) @(posedge clk_i);
    $display("Ran %0d items and compared %0d results across %0d stop threshold writes.",
             items_sent, sums_checked, thr_writes);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #240_000_000;
    $display("Timed out with %0d results still outstanding.", expected_sums.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ase_pkg.sv
rtl/ase_divider.sv
rtl/ase_datapath.sv
rtl/ase_sequencer.sv
rtl/atanh_series_evaluator.sv
dv/tb.sv
